[sv/synth_voice_allocator_macros.svh]
// assertion macros for the voice allocator
// no dependencies; every use expects clk and rst in scope

`ifndef SYNTH_VOICE_ALLOCATOR_MACROS_SVH
`define SYNTH_VOICE_ALLOCATOR_MACROS_SVH

// consequent checked in the same cycle
`define SVA_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle
`define SVA_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/svalloc_pkg.sv]
// shared constants, codes and controller/datapath interface types
// for the voice allocator; no dependencies
`timescale 1ns / 1ps

package svalloc_pkg;

  // voice store dimensions
  localparam int MAX_VOICES = 16;
  localparam int AGE_BITS   = 16;
  localparam int VIDX_W     = $clog2(MAX_VOICES);
  localparam int CNT_W      = $clog2(MAX_VOICES + 1);
  localparam int KEY_W      = 7;
  localparam int VEL_W      = 7;

  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

  // request codes
  localparam logic [1:0] REQ_NOTE_ON  = 2'd0;
  localparam logic [1:0] REQ_NOTE_OFF = 2'd1;
  localparam logic [1:0] REQ_FINISHED = 2'd2;

  // outcome codes
  localparam logic [2:0] OUT_TAKEN    = 3'd0;
  localparam logic [2:0] OUT_STOLEN   = 3'd1;
  localparam logic [2:0] OUT_RELEASED = 3'd2;
  localparam logic [2:0] OUT_NOMATCH  = 3'd3;
  localparam logic [2:0] OUT_FREED    = 3'd4;

  // decoded kind of the captured request
  typedef enum logic [1:0] {
    KIND_ALLOC,
    KIND_RELEASE,
    KIND_FREE,
    KIND_NONE
  } req_kind_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_AGE,
    OP_NEXT,
    OP_TAKE,
    OP_STEAL,
    OP_RELEASE,
    OP_FREE,
    OP_NOMATCH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    req_kind_t kind;
    logic      cur_idle;
    logic      cur_match;
    logic      last;
    logic      fin_ok;
    logic      out_free;
  } dp_stat_t;

endpackage

[sv/svalloc_dp.sv]
// voice allocator datapath: voice store, scan index, oldest tracker,
// result register; uses svalloc_pkg
`timescale 1ns / 1ps

module svalloc_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wen,
  input  logic [4:0]          cfg_wdata,
  input  logic [23:0]         s_tdata,   // key[6:0], velocity[13:7], finished_voice[17:14]
  input  logic [1:0]          s_tuser,   // req_type
  input  svalloc_pkg::dp_cmd_t  cmd,
  output svalloc_pkg::dp_stat_t stat,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [23:0]         m_tdata,   // voice[3:0], start_key[10:4], start_level[17:11]
  output logic [2:0]          m_tuser    // outcome
);

  localparam int NV = svalloc_pkg::MAX_VOICES;
  localparam int VW = svalloc_pkg::VIDX_W;
  localparam int CW = svalloc_pkg::CNT_W;
  localparam int AW = svalloc_pkg::AGE_BITS;
  localparam int KW = svalloc_pkg::KEY_W;
  localparam int LW = svalloc_pkg::VEL_W;

  logic [CW-1:0] n_act;
  logic [CW-1:0] n_clamp;

  logic [1:0]    req_q;
  logic [KW-1:0] key_q;
  logic [LW-1:0] vel_q;
  logic [VW-1:0] fin_q;

  logic [VW-1:0] idx;
  logic [VW-1:0] best_idx;
  logic [AW-1:0] best_age;

  logic [NV-1:0] busy;
  logic [NV-1:0] kv;
  logic [KW-1:0] vkey [NV];
  logic [AW-1:0] vage [NV];

  logic [AW-1:0] age_inc;
  logic          res_load;

  logic [VW-1:0] res_voice;
  logic [2:0]    res_outcome;
  logic [KW-1:0] res_key;
  logic [LW-1:0] res_level;

  // clamp the written count into one .. MAX_VOICES
  always_comb begin
    if (cfg_wdata == '0) begin
      n_clamp = CW'(1);
    end else if (CW'(cfg_wdata) > CW'(NV)) begin
      n_clamp = CW'(NV);
    end else begin
      n_clamp = CW'(cfg_wdata);
    end
  end

  // saturating age of the voice under the scan index
  assign age_inc = (vage[idx] == svalloc_pkg::AGE_MAX) ? vage[idx] : vage[idx] + 1'b1;

  // status towards the controller
  always_comb begin
    if (req_q == svalloc_pkg::REQ_NOTE_ON && vel_q != '0) begin
      stat.kind = svalloc_pkg::KIND_ALLOC;
    end else if (req_q == svalloc_pkg::REQ_NOTE_ON || req_q == svalloc_pkg::REQ_NOTE_OFF) begin
      stat.kind = svalloc_pkg::KIND_RELEASE;
    end else if (req_q == svalloc_pkg::REQ_FINISHED) begin
      stat.kind = svalloc_pkg::KIND_FREE;
    end else begin
      stat.kind = svalloc_pkg::KIND_NONE;
    end
    stat.cur_idle  = !busy[idx];
    stat.cur_match = busy[idx] && kv[idx] && (vkey[idx] == key_q);
    stat.last      = (CW'(idx) == n_act - 1'b1);
    stat.fin_ok    = (CW'(fin_q) < n_act);
    stat.out_free  = !m_tvalid || m_tready;
  end

  // voice store, captured item and scan registers
  always_ff @(posedge clk) begin
    if (rst || cfg_wen) begin
      n_act <= rst ? CW'(NV) : n_clamp;
      busy  <= '0;
      kv    <= '0;
      for (int v = 0; v < NV; v++) begin
        vkey[v] <= '0;
        vage[v] <= '0;
      end
    end else begin
      case (cmd.op)
        svalloc_pkg::OP_CAPTURE: begin
          req_q    <= s_tuser;
          key_q    <= s_tdata[KW-1:0];
          vel_q    <= s_tdata[KW+LW-1:KW];
          fin_q    <= s_tdata[KW+LW+VW-1:KW+LW];
          idx      <= '0;
          best_idx <= '0;
          best_age <= '0;
        end
        svalloc_pkg::OP_AGE: begin
          vage[idx] <= age_inc;
          if (idx == '0 || age_inc > best_age) begin
            best_idx <= idx;
            best_age <= age_inc;
          end
          idx <= idx + 1'b1;
        end
        svalloc_pkg::OP_NEXT: begin
          idx <= idx + 1'b1;
        end
        svalloc_pkg::OP_TAKE: begin
          busy[idx] <= 1'b1;
          kv[idx]   <= 1'b1;
          vkey[idx] <= key_q;
          vage[idx] <= '0;
        end
        svalloc_pkg::OP_STEAL: begin
          busy[best_idx] <= 1'b1;
          kv[best_idx]   <= 1'b1;
          vkey[best_idx] <= key_q;
          vage[best_idx] <= '0;
        end
        svalloc_pkg::OP_RELEASE: begin
          kv[idx]   <= 1'b0;
          vkey[idx] <= '0;
        end
        svalloc_pkg::OP_FREE: begin
          busy[fin_q] <= 1'b0;
          kv[fin_q]   <= 1'b0;
          vkey[fin_q] <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // result selection for the closing operation
  always_comb begin
    res_load    = 1'b1;
    res_voice   = '0;
    res_outcome = svalloc_pkg::OUT_NOMATCH;
    res_key     = '0;
    res_level   = '0;
    case (cmd.op)
      svalloc_pkg::OP_TAKE: begin
        res_voice   = idx;
        res_outcome = svalloc_pkg::OUT_TAKEN;
        res_key     = key_q;
        res_level   = vel_q;
      end
      svalloc_pkg::OP_STEAL: begin
        res_voice   = best_idx;
        res_outcome = svalloc_pkg::OUT_STOLEN;
        res_key     = key_q;
        res_level   = vel_q;
      end
      svalloc_pkg::OP_RELEASE: begin
        res_voice   = idx;
        res_outcome = svalloc_pkg::OUT_RELEASED;
      end
      svalloc_pkg::OP_FREE: begin
        res_voice   = fin_q;
        res_outcome = svalloc_pkg::OUT_FREED;
      end
      svalloc_pkg::OP_NOMATCH: begin
        res_outcome = svalloc_pkg::OUT_NOMATCH;
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  // output register, valid until the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      m_tdata <= {6'd0, res_level, res_key, res_voice};
      m_tuser <= res_outcome;
    end
  end

endmodule

[sv/svalloc_ctrl.sv]
// voice allocator controller: sequences capture, scan and result steps
// uses svalloc_pkg; drives svalloc_dp through the command struct
`timescale 1ns / 1ps

module svalloc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  svalloc_pkg::dp_stat_t stat,
  output svalloc_pkg::dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ON_SCAN,
    ST_STEAL,
    ST_OFF_SCAN,
    ST_FREE,
    ST_NOMATCH
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == ST_IDLE);

  // next state and datapath command
  always_comb begin
    state_next = state;
    cmd.op     = svalloc_pkg::OP_NONE;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.op     = svalloc_pkg::OP_CAPTURE;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (stat.kind)
          svalloc_pkg::KIND_ALLOC:   state_next = ST_ON_SCAN;
          svalloc_pkg::KIND_RELEASE: state_next = ST_OFF_SCAN;
          svalloc_pkg::KIND_FREE:    state_next = stat.fin_ok ? ST_FREE : ST_NOMATCH;
          default:                   state_next = ST_NOMATCH;
        endcase
      end
      // age busy voices until an idle one turns up or the last voice is aged
      ST_ON_SCAN: begin
        if (stat.cur_idle) begin
          if (stat.out_free) begin
            cmd.op     = svalloc_pkg::OP_TAKE;
            state_next = ST_IDLE;
          end
        end else begin
          cmd.op = svalloc_pkg::OP_AGE;
          if (stat.last) begin
            state_next = ST_STEAL;
          end
        end
      end
      ST_STEAL: begin
        if (stat.out_free) begin
          cmd.op     = svalloc_pkg::OP_STEAL;
          state_next = ST_IDLE;
        end
      end
      // look for the first busy voice holding the key
      ST_OFF_SCAN: begin
        if (stat.cur_match) begin
          if (stat.out_free) begin
            cmd.op     = svalloc_pkg::OP_RELEASE;
            state_next = ST_IDLE;
          end
        end else if (stat.last) begin
          state_next = ST_NOMATCH;
        end else begin
          cmd.op = svalloc_pkg::OP_NEXT;
        end
      end
      ST_FREE: begin
        if (stat.out_free) begin
          cmd.op     = svalloc_pkg::OP_FREE;
          state_next = ST_IDLE;
        end
      end
      ST_NOMATCH: begin
        if (stat.out_free) begin
          cmd.op     = svalloc_pkg::OP_NOMATCH;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[sv/synth_voice_allocator.sv]
// voice allocator top level: joins controller and datapath
// depends on svalloc_pkg, svalloc_ctrl, svalloc_dp and the assertion macros
//
//   channel   dir  handshake          payload
//   s_*       in   s_tvalid/s_tready  tdata key, velocity, finished_voice; tuser req_type
//   m_*       out  m_tvalid/m_tready  tdata voice, start_key, start_level; tuser outcome
//   cfg_*     in   cfg_wen            cfg_wdata enabled_voices
//
// one item at a time; a note on is decoded, then scanned up to the first idle
// voice, or up to the last of the n enabled voices and then stolen; a note off
// scans up to the first match among the n enabled voices: the scan checks one
// voice a cycle through a single age incrementer and compare. a voice finished event is decoded, then freed.
// reset is synchronous, with no clearing pass.
// a result waiting in the output register holds only the closing step.
`timescale 1ns / 1ps
`include "synth_voice_allocator_macros.svh"

module synth_voice_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // key[6:0], velocity[13:7], finished_voice[17:14]
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // voice[3:0], start_key[10:4], start_level[17:11]
  output logic [2:0]  m_tuser,   // outcome[2:0]
  input  logic        cfg_wen,
  input  logic [4:0]  cfg_wdata  // enabled_voices
);

  svalloc_pkg::dp_cmd_t  cmd;
  svalloc_pkg::dp_stat_t stat;

  svalloc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  svalloc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd       (cmd),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  // a result is only loaded when the output register can take it
  `SVA_SAME(a_res_room, (cmd.op == svalloc_pkg::OP_TAKE || cmd.op == svalloc_pkg::OP_STEAL || cmd.op == svalloc_pkg::OP_RELEASE || cmd.op == svalloc_pkg::OP_FREE || cmd.op == svalloc_pkg::OP_NOMATCH), stat.out_free, "result loaded over a pending beat")
  // after an accepted beat the block works on that item alone
  `SVA_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "input taken while an item is in work")
  // an allocating result always carries a nonzero level
  `SVA_SAME(a_alloc_level, m_tvalid && (m_tuser == svalloc_pkg::OUT_TAKEN || m_tuser == svalloc_pkg::OUT_STOLEN), m_tdata[17:11] != 7'd0, "allocation with zero level")

endmodule

[tb/tb.sv]
// self-checking testbench for synth_voice_allocator: directed and random note events,
// predicted by a scoreboard class and checked beat by beat on the result stream
// depends on svalloc_pkg and the synth_voice_allocator rtl
`timescale 1ns / 1ps

module tb;
  import svalloc_pkg::*;

  localparam logic [1:0]  REQ_UNKNOWN   = 2'd3;
  localparam int          SETTLE_CYCLES = 24;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          PHASE_ITEMS   = 250;
  localparam int          REPORT_MAX    = 50;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;

  // one result beat, fields as the block reports them
  typedef struct packed {
    logic [VIDX_W-1:0] voice;
    logic [2:0]        outcome;
    logic [KEY_W-1:0]  start_key;
    logic [VEL_W-1:0]  start_level;
  } voice_result_t;

  // voice table mirror and queue of predicted result beats
  class voice_alloc_scoreboard;
    logic                busy      [MAX_VOICES];
    logic [KEY_W-1:0]    held_key  [MAX_VOICES];
    logic                key_held  [MAX_VOICES];
    logic [AGE_BITS-1:0] age       [MAX_VOICES];
    logic [4:0]          voice_count;
    voice_result_t       expected_q[$];
    int unsigned         errors;

    function new();
      voice_count = 5'd16;
      errors = 0;
      clear_voices();
    endfunction

    function void clear_voices();
      for (int v = 0; v < MAX_VOICES; v++) begin
        busy[v] = 1'b0;
        held_key[v] = '0;
        key_held[v] = 1'b0;
        age[v] = '0;
      end
    endfunction

    // zero counts as one voice, anything above the store size as the full store
    function int unsigned active_voices();
      if (voice_count == 0) return 1;
      if (voice_count > MAX_VOICES) return MAX_VOICES;
      return 32'(voice_count);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_config(logic [4:0] value);
      voice_count = value;
      clear_voices();
    endfunction

    function void note_input(logic [1:0] req, logic [KEY_W-1:0] k, logic [VEL_W-1:0] vel,
                             logic [VIDX_W-1:0] fv);
      int unsigned   n;
      int unsigned   chosen;
      bit            found;
      voice_result_t r;
      n = active_voices();
      r = '0;
      found = 1'b0;
      chosen = 0;
      if (req == REQ_NOTE_ON && vel != '0) begin
        // scan for the first idle voice, ageing busy voices on the way
        for (int v = 0; v < n; v++) begin
          if (!found) begin
            if (!busy[v]) begin
              chosen = v;
              found = 1'b1;
            end else if (age[v] != AGE_MAX) begin
              age[v] = age[v] + 1'b1;
            end
          end
        end
        if (found) begin
          r.outcome = OUT_TAKEN;
        end else begin
          // steal the oldest voice, lowest index on a tie
          chosen = 0;
          for (int v = 1; v < n; v++)
            if (age[v] > age[chosen]) chosen = v;
          r.outcome = OUT_STOLEN;
        end
        age[chosen] = '0;
        held_key[chosen] = k;
        key_held[chosen] = 1'b1;
        busy[chosen] = 1'b1;
        r.voice = VIDX_W'(chosen);
        r.start_key = k;
        r.start_level = vel;
      end else if (req == REQ_NOTE_ON || req == REQ_NOTE_OFF) begin
        // release the first busy voice holding the key
        r.outcome = OUT_NOMATCH;
        for (int v = 0; v < n; v++) begin
          if (!found && busy[v] && key_held[v] && held_key[v] == k) begin
            found = 1'b1;
            held_key[v] = '0;
            key_held[v] = 1'b0;
            r.voice = VIDX_W'(v);
            r.outcome = OUT_RELEASED;
          end
        end
      end else if (req == REQ_FINISHED && fv < n) begin
        // freeing keeps the age
        busy[fv] = 1'b0;
        held_key[fv] = '0;
        key_held[fv] = 1'b0;
        r.voice = fv;
        r.outcome = OUT_FREED;
      end else begin
        r.outcome = OUT_NOMATCH;
      end
      expected_q.push_back(r);
    endfunction

    function void report_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(voice_result_t got);
      voice_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("%0t ns: unexpected beat, expected none, got voice %0d outcome %0d",
                   $time, got.voice, got.outcome);
        return;
      end
      want = expected_q.pop_front();
      report_field("voice", 32'(want.voice), 32'(got.voice));
      report_field("outcome", 32'(want.outcome), 32'(got.outcome));
      report_field("start_key", 32'(want.start_key), 32'(got.start_key));
      report_field("start_level", 32'(want.start_level), 32'(got.start_level));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // key[6:0], velocity[13:7], finished_voice[17:14]
  logic [1:0]  s_tuser;   // req_type[1:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // voice[3:0], start_key[10:4], start_level[17:11]
  logic [2:0]  m_tuser;   // outcome[2:0]
  logic        cfg_wen;
  logic [4:0]  cfg_wdata; // enabled_voices

  voice_alloc_scoreboard sb;
  int unsigned           send_idle_pct;
  int unsigned           recv_idle_pct;
  bit                    hold_req;
  int unsigned           cycle_count;
  logic [KEY_W-1:0]      key_pool [12];
  logic [4:0]            phase_counts [6];

  synth_voice_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // monitor: result beat first, then the input beat of the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready)
        sb.check_result({m_tdata[3:0], m_tuser, m_tdata[10:4], m_tdata[17:11]});
      if (s_tvalid && s_tready)
        sb.note_input(s_tuser, s_tdata[6:0], s_tdata[13:7], s_tdata[17:14]);
    end
  end

  // result side: random back-pressure, plus one long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // offer one beat from a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input logic [1:0] rq, input logic [KEY_W-1:0] k,
                           input logic [VEL_W-1:0] vel, input logic [VIDX_W-1:0] fv);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, fv, vel, k};
    s_tuser <= rq;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // stop offering and let every predicted beat come out
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_voice_count(input logic [4:0] value);
    drain();
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    sb.note_config(value);
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  // mostly keys from a small pool so that note offs find their voices
  function automatic logic [KEY_W-1:0] pool_key();
    if ($urandom_range(99) < 15) return KEY_W'($urandom);
    return key_pool[$urandom_range(11)];
  endfunction

  task automatic send_random_item();
    int unsigned       pick;
    logic [1:0]        rq;
    logic [KEY_W-1:0]  k;
    logic [VEL_W-1:0]  vel;
    logic [VIDX_W-1:0] fv;
    pick = $urandom_range(99);
    rq = REQ_NOTE_ON;
    k = KEY_W'($urandom);
    vel = VEL_W'($urandom);
    fv = VIDX_W'($urandom);
    if (pick < 50) begin
      k = pool_key();
      vel = VEL_W'($urandom_range(127, 1));
    end else if (pick < 56) begin
      k = pool_key();
      vel = '0;
    end else if (pick < 72) begin
      rq = REQ_NOTE_OFF;
      k = pool_key();
    end else if (pick < 94) begin
      rq = REQ_FINISHED;
      if ($urandom_range(99) < 75) fv = VIDX_W'($urandom_range(sb.active_voices() - 1));
    end else begin
      rq = REQ_UNKNOWN;
    end
    send_item(rq, k, vel, fv);
  endtask

  // main sequence
  initial begin
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    hold_req = 1'b0;
    send_idle_pct = 16;
    recv_idle_pct = 82;
    phase_counts[0] = 5'd16;
    phase_counts[1] = 5'd3;
    phase_counts[2] = 5'd1;
    phase_counts[3] = 5'd31;
    phase_counts[4] = 5'd8;
    phase_counts[5] = 5'($urandom);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: full store, field extremes and every request
    write_voice_count(5'd16);
    send_item(REQ_NOTE_ON, 7'd0, 7'd127, 4'd15);
    send_item(REQ_NOTE_ON, 7'd127, 7'd1, 4'd0);
    send_item(REQ_NOTE_OFF, 7'd127, 7'd127, 4'd15);
    send_item(REQ_NOTE_OFF, 7'd5, 7'd0, 4'd0);
    send_item(REQ_NOTE_ON, 7'd0, 7'd0, 4'd0);
    send_item(REQ_FINISHED, 7'd127, 7'd127, 4'd0);
    send_item(REQ_FINISHED, 7'd0, 7'd0, 4'd0);
    send_item(REQ_FINISHED, 7'd0, 7'd0, 4'd15);
    send_item(REQ_UNKNOWN, KEY_W'($urandom), VEL_W'($urandom), VIDX_W'($urandom));

    // two voices: steal, finish beyond the count, note off after free
    write_voice_count(5'd2);
    send_item(REQ_NOTE_ON, 7'd10, 7'd64, 4'd0);
    send_item(REQ_NOTE_ON, 7'd11, 7'd65, 4'd0);
    send_item(REQ_NOTE_ON, 7'd12, 7'd66, 4'd0);
    send_item(REQ_FINISHED, 7'd0, 7'd0, 4'd2);
    send_item(REQ_FINISHED, 7'd0, 7'd0, 4'd1);
    send_item(REQ_NOTE_OFF, 7'd11, 7'd0, 4'd0);

    // zero count behaves as one voice
    write_voice_count(5'd0);
    send_item(REQ_NOTE_ON, 7'd20, 7'd100, 4'd0);
    send_item(REQ_NOTE_ON, 7'd21, 7'd101, 4'd0);

    // count above the store behaves as the full store
    write_voice_count(5'd31);
    send_item(REQ_NOTE_ON, 7'd30, 7'd127, 4'd0);
    send_item(REQ_FINISHED, 7'd0, 7'd0, 4'd15);

    // random phases at several voice counts and idling patterns
    for (int phase = 0; phase < 6; phase++) begin
      write_voice_count(phase_counts[phase]);
      case (phase / 2)
        0: begin
          send_idle_pct = 16;
          recv_idle_pct = 82;
        end
        1: begin
          send_idle_pct = 82;
          recv_idle_pct = 16;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int i = 0; i < 12; i++) key_pool[i] = KEY_W'($urandom);
      if (phase == 4) hold_req = 1'b1;
      repeat (PHASE_ITEMS) send_random_item();
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
